// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/fcim_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fcim_pkg
// Constants, types and the quarter-wave amplitude table of the framed
// CPFSK I/Q modulator.
// ---------------------------------------------------------------------------
package fcim_pkg;

    // Sizes
    localparam int MESSAGE_DEPTH    = 256;
    localparam int DAC_BITS         = 12;
    localparam int SAMPLE_SHIFT     = 4;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 32;

    localparam int MSG_AW    = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
    localparam int SINE_AW   = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER   = SINE_TABLE_DEPTH / 4;
    localparam int QLOW_W    = $clog2(QUARTER);
    localparam int QIDX_W    = $clog2(QUARTER + 1);
    localparam int MAG_BITS  = DAC_BITS - 1;
    localparam int DAC_PEAK  = (1 << (DAC_BITS - 1)) - 1;

    // Port widths
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int SPB_W       = 20;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;
    localparam int BIT_VALUE_POS = 32;

    // Line coding
    localparam int unsigned LAST_BIT_IN_BYTE = 9;
    localparam logic [7:0]  IDLE_BYTE        = 8'hFF;

    // Fixed-point constants for the table build
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned SINE_ROUND  = SINE_TABLE_DEPTH / 2;
    localparam longint unsigned MAG_DEN     = 64'd10 * ONE_Q30;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARK_STEP   = 3'd0,
        CFG_SPACE_STEP  = 3'd1,
        CFG_SPB         = 3'd2,
        CFG_PRE_COUNT   = 3'd3,
        CFG_PRE_VALUE   = 3'd4,
        CFG_SYNC_VALUE  = 3'd5,
        CFG_MSG_LENGTH  = 3'd6,
        CFG_GAP_BITS    = 3'd7
    } cfg_idx_t;

    // Frame sections
    typedef enum logic [2:0] {
        SEC_PREAMBLE = 3'd0,
        SEC_SYNC     = 3'd1,
        SEC_LENGTH   = 3'd2,
        SEC_MESSAGE  = 3'd3,
        SEC_GAP      = 3'd4
    } sec_t;

    // Item kinds on the input tuser
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef logic [(QUARTER+1)*MAG_BITS-1:0] mag_rom_t;

    // sin(pi/2 * r / SINE_TABLE_DEPTH) in Q30, Taylor series to x^13
    function automatic longint unsigned sine_q30(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned sum;
        longint unsigned term;
        begin
            x    = (PI_HALF_Q30 * r + SINE_ROUND) >> SINE_AW;
            x2   = (x * x) >> 30;
            sum  = x;
            term = x;
            for (int k = 1; k <= 6; k++)
            begin
                term = (term * x2) >> 30;
                case (k)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    default: term = term / 156;
                endcase
                if (k[0])
                    sum = (sum >= term) ? sum - term : 64'd0;
                else
                    sum = sum + term;
            end
            sine_q30 = (sum > ONE_Q30) ? ONE_Q30 : sum;
        end
    endfunction

    // Quarter-wave magnitude table, entries 0..QUARTER, built at elaboration
    function automatic mag_rom_t build_mag_rom();
        mag_rom_t        rom;
        longint unsigned s;
        longint unsigned mag;
        begin
            rom = '0;
            for (int j = 0; j <= QUARTER; j++)
            begin
                s   = sine_q30(64'(4 * j));
                mag = (64'd7 * 64'(DAC_PEAK) * s + 64'd5 * ONE_Q30) / MAG_DEN;
                rom[j*MAG_BITS +: MAG_BITS] = mag[MAG_BITS-1:0];
            end
            build_mag_rom = rom;
        end
    endfunction

    localparam mag_rom_t MAG_ROM = build_mag_rom();

    // 16-bit DAC word for quadrant quad and position j within it
    function automatic logic [15:0] sample_word(input logic [1:0] quad,
                                                input logic [QLOW_W-1:0] j);
        logic [QIDX_W-1:0]          idx;
        logic [MAG_BITS-1:0]        mag;
        logic signed [DAC_BITS-1:0] v;
        logic signed [31:0]         w;
        begin
            idx = quad[0] ? (QIDX_W'(QUARTER) - {1'b0, j}) : {1'b0, j};
            mag = MAG_ROM[idx*MAG_BITS +: MAG_BITS];
            v   = quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
            w   = 32'(v);
            w   = w <<< SAMPLE_SHIFT;
            sample_word = w[15:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/framed_cpfsk_iq_modulator.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// framed_cpfsk_iq_modulator
// Continuous-phase 2-FSK I/Q source sending a repeating framed message.
// ---------------------------------------------------------------------------
// Takes one item per clock unless an untaken sample stalls it. A tick item
// (tuser 1) yields one I/Q sample on the output in the next cycle; a load
// item (tuser 0) writes one byte of the message memory and yields nothing.
// The sample path is one phase accumulator add and two quarter-wave table
// lookups per cycle, which sets the rate of one item per clock. The output
// register is refilled in the cycle it is taken, so ready only drops while a
// sample sits untaken. Message bytes are read from a synchronous memory at
// the start of each message byte; the value is needed only after the start
// bit, so its read latency never stalls. The message memory has no reset and
// needs no clearing pass: load every entry that the frame will send.
// ---------------------------------------------------------------------------
module framed_cpfsk_iq_modulator
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [fcim_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fcim_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [fcim_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] msg_index, [15:8] msg_byte
    input  wire logic                              s_tuser,   // [0] op
    // Result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [fcim_pkg::OUT_TDATA_W-1:0]       m_tdata,   // [15:0] i_word, [31:16] q_word,
                                                              // [32] bit_value, [39:33] zero
    output logic [fcim_pkg::OUT_TUSER_W-1:0]       m_tuser    // [0] bit_start, [1] frame_start
);
    import fcim_pkg::*;

    // Configuration registers
    logic [31:0]      mark_step_reg;
    logic [31:0]      space_step_reg;
    logic [SPB_W-1:0] spb_reg;
    logic [7:0]       pre_count_reg;
    logic [7:0]       pre_value_reg;
    logic [7:0]       sync_value_reg;
    logic [7:0]       msg_len_reg;
    logic [7:0]       gap_bits_reg;

    // Modulator state
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [SPB_W-1:0]      sib_reg, sib_next;
    logic [3:0]            bib_reg, bib_next;
    logic [7:0]            cnt_reg, cnt_next;
    sec_t                  sec_reg, sec_next;
    logic [7:0]            cur_byte_reg, cur_byte_next;
    logic                  from_mem_reg, from_mem_next;

    // Message memory
    logic [7:0]        msg_mem [MESSAGE_DEPTH];
    logic [7:0]        mem_rd_reg;
    logic              mem_rd_en;
    logic [MSG_AW-1:0] mem_rd_addr;
    logic              load_wr;

    // Output register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] i_word_reg, q_word_reg;
    logic        bit_value_reg, bit_start_reg, frame_start_reg;

    // Handshake
    logic       accept;
    logic       tick;
    logic [7:0] msg_index;
    logic [7:0] msg_byte;

    assign msg_index = s_tdata[7:0];
    assign msg_byte  = s_tdata[15:8];
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign tick      = accept && (op_t'(s_tuser) == OP_TICK);
    assign load_wr   = accept && (op_t'(s_tuser) == OP_LOAD)
                       && ({1'b0, msg_index} < 9'(MESSAGE_DEPTH));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_step_reg  <= '0;
            space_step_reg <= '0;
            spb_reg        <= SPB_W'(115200);
            pre_count_reg  <= '0;
            pre_value_reg  <= '0;
            sync_value_reg <= '0;
            msg_len_reg    <= '0;
            gap_bits_reg   <= 8'd50;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MARK_STEP:  mark_step_reg  <= cfg_data;
                CFG_SPACE_STEP: space_step_reg <= cfg_data;
                CFG_SPB:        spb_reg        <= cfg_data[SPB_W-1:0];
                CFG_PRE_COUNT:  pre_count_reg  <= cfg_data[7:0];
                CFG_PRE_VALUE:  pre_value_reg  <= cfg_data[7:0];
                CFG_SYNC_VALUE: sync_value_reg <= cfg_data[7:0];
                CFG_MSG_LENGTH: msg_len_reg    <= cfg_data[7:0];
                CFG_GAP_BITS:   gap_bits_reg   <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // Message memory: writes from loads, registered reads at message byte start.
    // Loads and ticks never share a cycle, so no same-entry collision occurs.
    always_ff @(posedge clk)
    begin
        if (load_wr)
            msg_mem[msg_index[MSG_AW-1:0]] <= msg_byte;
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
            mem_rd_reg <= msg_mem[mem_rd_addr];
    end

    // Per-sample sequencing and sample generation
    logic [SPB_W-1:0]   spb;
    logic [SPB_W-1:0]   sib;
    logic               bstart;
    logic               fstart;
    logic               byte_start;
    logic [7:0]         sec_limit;
    logic               advance;
    logic               wrap;
    sec_t               sec_cur;
    logic [7:0]         cnt_cur;
    logic [7:0]         cur_byte;
    logic               line_bit;
    logic [SINE_AW-1:0] k;
    logic [1:0]         quad_s;
    logic [1:0]         quad_c;
    logic [15:0]        i_word;
    logic [15:0]        q_word;

    // Next section after the current one is used up, skipping empty ones
    always_comb
    begin
        sec_limit = gap_bits_reg;
        case (sec_reg)
            SEC_PREAMBLE: sec_limit = pre_count_reg;
            SEC_SYNC:     sec_limit = 8'd1;
            SEC_LENGTH:   sec_limit = 8'd1;
            SEC_MESSAGE:  sec_limit = msg_len_reg;
            default:      sec_limit = gap_bits_reg;
        endcase
        advance = (cnt_reg >= sec_limit);
        wrap    = 1'b0;
        sec_cur = sec_reg;
        if (advance)
        begin
            case (sec_reg)
                SEC_PREAMBLE: sec_cur = SEC_SYNC;
                SEC_SYNC:     sec_cur = SEC_LENGTH;
                SEC_LENGTH:
                begin
                    if (msg_len_reg != 8'd0)
                        sec_cur = SEC_MESSAGE;
                    else if (gap_bits_reg != 8'd0)
                        sec_cur = SEC_GAP;
                    else
                    begin
                        wrap    = 1'b1;
                        sec_cur = (pre_count_reg != 8'd0) ? SEC_PREAMBLE : SEC_SYNC;
                    end
                end
                SEC_MESSAGE:
                begin
                    if (gap_bits_reg != 8'd0)
                        sec_cur = SEC_GAP;
                    else
                    begin
                        wrap    = 1'b1;
                        sec_cur = (pre_count_reg != 8'd0) ? SEC_PREAMBLE : SEC_SYNC;
                    end
                end
                default:
                begin
                    wrap    = 1'b1;
                    sec_cur = (pre_count_reg != 8'd0) ? SEC_PREAMBLE : SEC_SYNC;
                end
            endcase
        end
    end

    always_comb
    begin
        spb        = (spb_reg == '0) ? SPB_W'(1) : spb_reg;
        sib        = (sib_reg >= spb) ? '0 : sib_reg;
        bstart     = (sib == '0);
        byte_start = bstart && (bib_reg == 4'd0);
        cur_byte   = from_mem_reg ? mem_rd_reg : cur_byte_reg;

        phase_next    = phase_reg;
        sib_next      = sib_reg;
        bib_next      = bib_reg;
        cnt_next      = cnt_reg;
        sec_next      = sec_reg;
        cur_byte_next = cur_byte_reg;
        from_mem_next = from_mem_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = cnt_reg[MSG_AW-1:0];
        fstart        = 1'b0;

        // Section and byte selection at the start of each byte
        if (byte_start)
        begin
            fstart   = ((sec_reg == SEC_PREAMBLE) && (cnt_reg == 8'd0)) || wrap;
            sec_next = sec_cur;
            cnt_next = advance ? 8'd0 : cnt_reg;
            from_mem_next = 1'b0;
            case (sec_cur)
                SEC_PREAMBLE: cur_byte_next = pre_value_reg;
                SEC_SYNC:     cur_byte_next = sync_value_reg;
                SEC_LENGTH:   cur_byte_next = msg_len_reg;
                SEC_MESSAGE:
                begin
                    cur_byte_next = 8'd0;
                    if ({1'b0, cnt_next} < 9'(MESSAGE_DEPTH))
                    begin
                        mem_rd_en     = tick;
                        mem_rd_addr   = cnt_next[MSG_AW-1:0];
                        from_mem_next = 1'b1;
                    end
                end
                default:      cur_byte_next = IDLE_BYTE;
            endcase
        end

        // Line bit: start 0, data LSB first, stop and idle 1
        if ((sec_next == SEC_GAP) || (bib_reg >= 4'(LAST_BIT_IN_BYTE)))
            line_bit = 1'b1;
        else if (bib_reg == 4'd0)
            line_bit = 1'b0;
        else
            line_bit = cur_byte[3'(bib_reg - 4'd1)];

        // Oscillator lookup: cosine leads sine by one quadrant
        k      = phase_reg[PHASE_BITS-1 -: SINE_AW];
        quad_s = k[SINE_AW-1 -: 2];
        quad_c = quad_s + 2'd1;
        i_word = sample_word(quad_c, k[QLOW_W-1:0]);
        q_word = sample_word(quad_s, k[QLOW_W-1:0]);

        phase_next = phase_reg + (line_bit ? mark_step_reg : space_step_reg);

        // Bit and byte counters
        sib_next = sib + SPB_W'(1);
        if (sib_next >= spb)
        begin
            sib_next = '0;
            if (sec_next == SEC_GAP)
                cnt_next = cnt_next + 8'd1;
            else
            begin
                bib_next = bib_reg + 4'd1;
                if (bib_next > 4'(LAST_BIT_IN_BYTE))
                begin
                    bib_next = 4'd0;
                    cnt_next = cnt_next + 8'd1;
                end
            end
        end
    end

    // State registers, updated on tick items only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            sib_reg      <= '0;
            bib_reg      <= '0;
            cnt_reg      <= '0;
            sec_reg      <= SEC_PREAMBLE;
            cur_byte_reg <= '0;
            from_mem_reg <= 1'b0;
        end
        else if (tick)
        begin
            phase_reg    <= phase_next;
            sib_reg      <= sib_next;
            bib_reg      <= bib_next;
            cnt_reg      <= cnt_next;
            sec_reg      <= sec_next;
            cur_byte_reg <= cur_byte_next;
            from_mem_reg <= from_mem_next;
        end
    end

    // Output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (tick)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            i_word_reg      <= i_word;
            q_word_reg      <= q_word;
            bit_value_reg   <= line_bit;
            bit_start_reg   <= bstart;
            frame_start_reg <= fstart;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W-BIT_VALUE_POS-1)'(0), bit_value_reg, q_word_reg, i_word_reg};
    assign m_tuser  = {frame_start_reg, bit_start_reg};

endmodule
`default_nettype wire

// ----- rtl/core/fcim_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fcim_checker
// Port-level checks on the framed CPFSK I/Q modulator, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fcim_checker
(
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [fcim_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input wire logic [fcim_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import fcim_pkg::*;

    // A stalled item holds
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A frame opens on the first sample of a start bit
    `ASSERT_IMPLY(a_frame_on_start_bit, m_tvalid && m_tuser[1], m_tuser[0] && !m_tdata[BIT_VALUE_POS])

    // Every accepted tick gives a sample next cycle
    `ASSERT_NEXT(a_tick_gives_item, s_tvalid && s_tready && s_tuser, m_tvalid)

    // A load gives no item
    `ASSERT_NEXT(a_load_silent, s_tvalid && s_tready && !s_tuser && (!m_tvalid || m_tready), !m_tvalid)

endmodule

bind framed_cpfsk_iq_modulator fcim_checker u_fcim_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
